// ----- rtl/core/bvop_pkg.sv -----
// ----------------------------------------------------------------------------
// BOOTP vendor option parser package
// Types, codes and constants shared by the parser modules.
// ----------------------------------------------------------------------------
package bvop_pkg;

  // Default size of the vendor area in bytes.
  localparam int unsigned AREA_BYTES_DEF = 64;
  // Reset value of the expected magic cookie.
  localparam logic [31:0] COOKIE_RESET = 32'h6382_5363;
  // Number of data bytes that make up a captured address.
  localparam int unsigned ADDR_BYTES = 4;
  // Depth of the result queue; a power of two of at least two.
  localparam int unsigned RES_FIFO_DEPTH = 4;

  // Option tags.
  localparam logic [7:0] TAG_PAD     = 8'd0;
  localparam logic [7:0] TAG_ROUTER  = 8'd3;
  localparam logic [7:0] TAG_TIME    = 8'd4;
  localparam logic [7:0] TAG_DNS     = 8'd6;
  localparam logic [7:0] TAG_LPR     = 8'd9;
  localparam logic [7:0] TAG_RLS     = 8'd11;
  localparam logic [7:0] TAG_END     = 8'd255;

  typedef enum logic [3:0] {
    KIND_GATEWAY     = 4'd0,
    KIND_TIME        = 4'd1,
    KIND_NAME        = 4'd2,
    KIND_PAGE        = 4'd3,
    KIND_FILE_SERVER = 4'd4,
    KIND_END_SEEN    = 4'd5,
    KIND_BAD_COOKIE  = 4'd6,
    KIND_SHORT_OPT   = 4'd7,
    KIND_NO_END      = 4'd8
  } kind_e;

  typedef enum logic [2:0] {
    OPT_GATEWAY     = 3'd0,
    OPT_TIME        = 3'd1,
    OPT_NAME        = 3'd2,
    OPT_PAGE        = 3'd3,
    OPT_FILE_SERVER = 3'd4,
    OPT_OTHER       = 3'd5
  } opt_kind_e;

  typedef enum logic [2:0] {
    PH_COOKIE  = 3'd0,
    PH_TAG     = 3'd1,
    PH_LEN     = 3'd2,
    PH_CAPTURE = 3'd3,
    PH_SKIP    = 3'd4,
    PH_DONE    = 3'd5
  } phase_e;

  typedef struct packed {
    logic [7:0] vend_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] address;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [6:0]  byte_position;
    phase_e      parse_phase;
    logic [31:0] cookie_shift;
    opt_kind_e   option_kind;
    logic [7:0]  skip_remaining;
    logic [2:0]  capture_count;
    logic [31:0] address_shift;
  } parse_state_t;

  // Results caused by one byte: up to two, the second always a missing End.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } step_res_t;

  localparam parse_state_t STATE_RESET = '{
    byte_position:  7'd0,
    parse_phase:    PH_COOKIE,
    cookie_shift:   32'd0,
    option_kind:    OPT_GATEWAY,
    skip_remaining: 8'd0,
    capture_count:  3'd0,
    address_shift:  32'd0
  };

endpackage

// ----- rtl/core/bvop_step.sv -----
// ----------------------------------------------------------------------------
// BOOTP vendor option parser step
// Combinational parse of one vendor byte against the current parser state.
// ----------------------------------------------------------------------------
module bvop_step import bvop_pkg::*; #(
  parameter int unsigned AreaBytes = AREA_BYTES_DEF
) (
  input  parse_state_t state_i,
  input  in_item_t     item_i,
  input  logic [31:0]  cookie_i,
  output parse_state_t state_o,
  output step_res_t    res_o
);

  parse_state_t nxt;
  logic         prim_valid;
  kind_e        prim_kind;
  logic [31:0]  prim_addr;
  logic         noend_valid;
  logic [7:0]   b;
  result_t      noend_res;
  result_t      prim_res;

  assign b = item_i.vend_byte;

  always_comb begin
    nxt        = state_i;
    prim_valid = 1'b0;
    prim_kind  = KIND_END_SEEN;
    prim_addr  = 32'd0;

    case (state_i.parse_phase)
      PH_COOKIE: begin
        nxt.cookie_shift = {state_i.cookie_shift[23:0], b};
        if (state_i.byte_position >= 7'(ADDR_BYTES - 1)) begin
          if (nxt.cookie_shift != cookie_i) begin
            prim_valid      = 1'b1;
            prim_kind       = KIND_BAD_COOKIE;
            nxt.parse_phase = PH_DONE;
          end else begin
            nxt.parse_phase = PH_TAG;
          end
        end
      end
      PH_TAG: begin
        if (b == TAG_END) begin
          prim_valid      = 1'b1;
          prim_kind       = KIND_END_SEEN;
          nxt.parse_phase = PH_DONE;
        end else if (b != TAG_PAD) begin
          case (b)
            TAG_ROUTER: nxt.option_kind = OPT_GATEWAY;
            TAG_TIME:   nxt.option_kind = OPT_TIME;
            TAG_DNS:    nxt.option_kind = OPT_NAME;
            TAG_LPR:    nxt.option_kind = OPT_PAGE;
            TAG_RLS:    nxt.option_kind = OPT_FILE_SERVER;
            default:    nxt.option_kind = OPT_OTHER;
          endcase
          nxt.parse_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        nxt.skip_remaining = b;
        if (state_i.option_kind != OPT_OTHER && b >= 8'(ADDR_BYTES)) begin
          nxt.capture_count = 3'd0;
          nxt.address_shift = 32'd0;
          nxt.parse_phase   = PH_CAPTURE;
        end else begin
          if (state_i.option_kind != OPT_OTHER) begin
            prim_valid = 1'b1;
            prim_kind  = KIND_SHORT_OPT;
          end
          nxt.parse_phase = (b != 8'd0) ? PH_SKIP : PH_TAG;
        end
      end
      PH_CAPTURE: begin
        nxt.address_shift  = {state_i.address_shift[23:0], b};
        nxt.capture_count  = state_i.capture_count + 3'd1;
        nxt.skip_remaining = state_i.skip_remaining - 8'd1;
        if (nxt.capture_count >= 3'(ADDR_BYTES)) begin
          prim_valid      = 1'b1;
          prim_kind       = kind_e'(4'(state_i.option_kind));
          prim_addr       = nxt.address_shift;
          nxt.parse_phase = (nxt.skip_remaining != 8'd0) ? PH_SKIP : PH_TAG;
        end
      end
      PH_SKIP: begin
        nxt.skip_remaining = state_i.skip_remaining - 8'd1;
        if (nxt.skip_remaining == 8'd0) begin
          nxt.parse_phase = PH_TAG;
        end
      end
      default: begin
        // Done: bytes are ignored until the final byte of the area.
      end
    endcase

    noend_valid = 1'b0;
    if (state_i.parse_phase != PH_DONE) begin
      nxt.byte_position = (state_i.byte_position != 7'h7F) ?
                          state_i.byte_position + 7'd1 : state_i.byte_position;
      if (nxt.parse_phase != PH_DONE &&
          (item_i.last_byte || nxt.byte_position >= 7'(AreaBytes))) begin
        noend_valid     = 1'b1;
        nxt.parse_phase = PH_DONE;
      end
    end

    state_o = item_i.last_byte ? STATE_RESET : nxt;
  end

  assign noend_res = '{kind: KIND_NO_END, address: 32'd0, last: 1'b1};
  assign prim_res  = '{kind: prim_kind, address: prim_addr, last: !noend_valid};

  assign res_o.count  = 2'({1'b0, prim_valid}) + 2'({1'b0, noend_valid});
  assign res_o.first  = prim_valid ? prim_res : noend_res;
  assign res_o.second = noend_res;

endmodule

// ----- rtl/core/bvop_result_fifo.sv -----
// ----------------------------------------------------------------------------
// BOOTP vendor option parser result queue
// Small queue that takes up to two results per cycle and hands out one unless stalled.
// ----------------------------------------------------------------------------
module bvop_result_fifo import bvop_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  step_res_t  push_i,
  output logic       room_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output result_t    out_data_o
);

  localparam int unsigned PtrW = $clog2(RES_FIFO_DEPTH);
  localparam int unsigned CntW = $clog2(RES_FIFO_DEPTH + 1);

  result_t         mem_q [RES_FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;

  assign pop         = (count_q != '0) && !out_stall_i;
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];

  // Room for two entries once this cycle's read is taken into account.
  assign room_o = ({1'b0, count_q} + (CntW + 1)'(2)) <=
                  ((CntW + 1)'(RES_FIFO_DEPTH) + (CntW + 1)'(pop));

  assign wr_ptr_d = wr_ptr_q + PtrW'(push_i.count);
  assign rd_ptr_d = rd_ptr_q + PtrW'(pop);
  assign count_d  = count_q + CntW'(push_i.count) - CntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= push_i.second;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(RES_FIFO_DEPTH))
    else $error("result queue count exceeds depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |->
      (({1'b0, count_q} + (CntW + 1)'(push_i.count)) <=
       ((CntW + 1)'(RES_FIFO_DEPTH) + (CntW + 1)'(pop))))
    else $error("result queue written while full");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_i.count == 2'd0) |=> count_q == $past(count_q) - CntW'(1))
    else $error("result queue count lost track of a read");

endmodule

// ----- rtl/core/bootp_vendor_option_parser.sv -----
// ----------------------------------------------------------------------------
// BOOTP vendor option parser
// Walks the BOOTP vendor extensions area one byte per transfer and reports
// captured server addresses and area status.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one vendor
//   byte per transfer plus a flag for the final byte of the area. The output
//   channel (out_valid_o / out_stall_i / out_data_o) carries one result per
//   transfer: a kind code, a 32-bit address and a flag on the last result
//   caused by a given byte. A byte causes zero, one or two results.
//   cfg_we_i / cfg_wdata_i write the expected magic cookie; write it only
//   while the parser is idle.
//   An accepted byte waits in the input register, is parsed there once the
//   result queue has room, and its results are offered from the queue head.
//   Throughput: one byte per cycle. The input register stalls only when the
//   four-entry result queue could not take two more results, so sustained
//   rate drops below one byte per cycle only if results pile up downstream.
//   Reset clears the parser to the cookie phase, empties the queue and loads
//   the default cookie. While out_stall_i is high the head result holds and
//   bytes flow on until the queue lacks room for two, then in_stall_o rises.
// ----------------------------------------------------------------------------
module bootp_vendor_option_parser import bvop_pkg::*; #(
  parameter int unsigned AREA_BYTES = AREA_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output result_t     out_data_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  // Input register holding the byte awaiting parse.
  logic         in_valid_q, in_valid_d;
  in_item_t     in_q;
  // Parser state and the cookie register.
  parse_state_t state_q, state_d;
  logic [31:0]  cookie_q;

  parse_state_t step_state;
  step_res_t    step_res;
  step_res_t    push;
  logic         room;
  logic         advance;
  logic         in_take;

  // The held byte is parsed once the result queue can absorb its results.
  assign advance    = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_valid_d = in_take || (in_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cookie_q <= COOKIE_RESET;
    end else if (cfg_we_i) begin
      cookie_q <= cfg_wdata_i;
    end
  end

  bvop_step #(
    .AreaBytes (AREA_BYTES)
  ) u_step (
    .state_i  (state_q),
    .item_i   (in_q),
    .cookie_i (cookie_q),
    .state_o  (step_state),
    .res_o    (step_res)
  );

  assign state_d = advance ? step_state : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else begin
      state_q <= state_d;
    end
  end

  // Results enter the queue only in the cycle the byte is parsed.
  always_comb begin
    push = step_res;
    if (!advance) begin
      push.count = 2'd0;
    end
  end

  bvop_result_fifo u_result_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && state_q.parse_phase == PH_DONE) |-> push.count == 2'd0)
    else $error("result produced after the area was finished");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_q.last_byte) |=>
      (state_q.parse_phase == PH_COOKIE && state_q.byte_position == 7'd0))
    else $error("parser did not restart after the final byte");

  a_final_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_q.last_byte && state_q.parse_phase != PH_DONE) |->
      push.count != 2'd0)
    else $error("final byte of an open area produced no result");

  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> state_q == $past(state_q))
    else $error("parser state moved without a parsed byte");

endmodule
